// ===== hdl/svpd_pkg.sv =====
package svpd_pkg;

    localparam int CORDIC_STEPS = 16;

    localparam logic [16:0] ATAN_UNITS [0:CORDIC_STEPS-1] = '{
        17'd49152, 17'd29016, 17'd15331, 17'd7782, 17'd3906, 17'd1955, 17'd978, 17'd489,
        17'd244, 17'd122, 17'd61, 17'd31, 17'd15, 17'd8, 17'd4, 17'd2
    };

    localparam logic [14:0] CORDIC_K_Q15 = 15'd19898;
    localparam logic [18:0] TURN_UNITS   = 19'd393216;
    localparam logic [17:0] HALF_TURN    = 18'd196608;
    localparam logic [16:0] QUARTER_TURN = 17'd98304;
    localparam logic [16:0] SECTOR_UNITS = 17'd65536;
    localparam logic [15:0] M_LIMIT      = 16'd37814;
    localparam logic [14:0] SQRT3_Q14    = 15'd28378;

    localparam logic [13:0] SUPPLY_RESET = 14'd3072;
    localparam logic [15:0] PERIOD_RESET = 16'd1280;

    localparam logic CFG_SUPPLY = 1'b0;
    localparam logic CFG_PERIOD = 1'b1;

endpackage

// ===== hdl/svpd_sine.sv =====
module svpd_sine import svpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [16:0] i_arg,
    output logic [14:0] o_sine
);

    logic signed [17:0] r_x [1:CORDIC_STEPS];
    logic signed [17:0] r_y [1:CORDIC_STEPS];
    logic signed [19:0] r_z [1:CORDIC_STEPS];
    logic signed [17:0] w_x [0:CORDIC_STEPS-1];
    logic signed [17:0] w_y [0:CORDIC_STEPS-1];
    logic signed [19:0] w_z [0:CORDIC_STEPS-1];
    logic signed [17:0] n_x [1:CORDIC_STEPS];
    logic signed [17:0] n_y [1:CORDIC_STEPS];
    logic signed [19:0] n_z [1:CORDIC_STEPS];

    always_comb begin
        w_x[0] = 18'(CORDIC_K_Q15);
        w_y[0] = '0;
        w_z[0] = 20'(i_arg);
        for (int k = 1; k < CORDIC_STEPS; k++) begin
            w_x[k] = r_x[k];
            w_y[k] = r_y[k];
            w_z[k] = r_z[k];
        end
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            if (w_z[k] >= 0) begin
                n_x[k+1] = w_x[k] - (w_y[k] >>> k);
                n_y[k+1] = w_y[k] + (w_x[k] >>> k);
                n_z[k+1] = w_z[k] - 20'(ATAN_UNITS[k]);
            end else begin
                n_x[k+1] = w_x[k] + (w_y[k] >>> k);
                n_y[k+1] = w_y[k] - (w_x[k] >>> k);
                n_z[k+1] = w_z[k] + 20'(ATAN_UNITS[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 1; k <= CORDIC_STEPS; k++) begin
                r_x[k] <= n_x[k];
                r_y[k] <= n_y[k];
                r_z[k] <= n_z[k];
            end
        end
    end

    always_comb begin
        if (r_y[CORDIC_STEPS] < 0) begin
            o_sine = '0;
        end else if (r_y[CORDIC_STEPS] > 18'sd32767) begin
            o_sine = 15'h7FFF;
        end else begin
            o_sine = r_y[CORDIC_STEPS][14:0];
        end
    end

endmodule

// ===== hdl/space_vector_pwm_duty.sv =====
// Space-vector PWM compare-count generator. Each item carries a q/d voltage command
// and a rotor angle and yields three phase compare counts plus the sector.
// The block is a fixed pipeline of 43 register stages: a new item is taken every
// cycle while the pipeline is not held, and the whole pipeline holds while a
// finished result is not taken. The depth is set by the 16-step square root and
// arctangent units, followed by the 16-step modulation-index divider running
// alongside the two sine units. The user must write supply voltage and PWM period
// only while the pipeline is empty; the block itself does not enforce this.
module space_vector_pwm_duty import svpd_pkg::*; #(
    parameter int ANGLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // q_voltage [15:0], d_voltage [31:16], rotor_angle [47:32]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // duty_a [15:0], duty_b [31:16], duty_c [47:32], sector_number [50:48]
    output logic [55:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int NST = 16;
    localparam int LAST = 42;

    logic        w_en;
    logic [LAST:0] r_v;
    logic [13:0] r_supply;
    logic [15:0] r_period;

    assign w_en = !r_v[LAST] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_v[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= '0;
            r_supply <= SUPPLY_RESET;
            r_period <= PERIOD_RESET;
        end else begin
            if (w_en) begin
                r_v <= {r_v[LAST-1:0], s_axis_tvalid};
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SUPPLY: r_supply <= i_cfg_data[13:0];
                    CFG_PERIOD: r_period <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Input, square, square-root and arctangent stages.
    logic signed [15:0] r0_q, r0_d, r1_q, r1_d;
    logic [ANGLE_BITS-1:0] r0_theta;
    logic [15:0] r1_theta;
    logic signed [31:0] r1_dd, r1_qq;

    logic [31:0] r_sn [0:NST];
    logic [31:0] r_sr [0:NST];
    logic signed [35:0] r_ax [0:NST];
    logic signed [35:0] r_ay [0:NST];
    logic signed [20:0] r_az [0:NST];
    logic        r_dnz  [0:NST];
    logic        r_cneg [0:NST];
    logic [15:0] r_qmag [0:NST];
    logic [15:0] r_cth  [0:NST];

    logic [31:0] n_sn [1:NST];
    logic [31:0] n_sr [1:NST];
    logic signed [35:0] n_ax [1:NST];
    logic signed [35:0] n_ay [1:NST];
    logic signed [20:0] n_az [1:NST];

    logic signed [35:0] w_x0, w_y0;

    assign w_x0 = $signed({{4{r1_d[15]}}, r1_d, 16'b0});
    assign w_y0 = $signed({{4{r1_q[15]}}, r1_q, 16'b0});

    always_comb begin
        logic [31:0] b;
        for (int k = 0; k < NST; k++) begin
            b = 32'(1) << (30 - 2 * k);
            if (r_sn[k] >= r_sr[k] + b) begin
                n_sn[k+1] = r_sn[k] - (r_sr[k] + b);
                n_sr[k+1] = (r_sr[k] >> 1) + b;
            end else begin
                n_sn[k+1] = r_sn[k];
                n_sr[k+1] = r_sr[k] >> 1;
            end
            if (r_ay[k] > 0) begin
                n_ax[k+1] = r_ax[k] + (r_ay[k] >>> k);
                n_ay[k+1] = r_ay[k] - (r_ax[k] >>> k);
                n_az[k+1] = r_az[k] + 21'(ATAN_UNITS[k]);
            end else begin
                n_ax[k+1] = r_ax[k] - (r_ay[k] >>> k);
                n_ay[k+1] = r_ay[k] + (r_ax[k] >>> k);
                n_az[k+1] = r_az[k] - 21'(ATAN_UNITS[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_q     <= s_axis_tdata[15:0];
            r0_d     <= s_axis_tdata[31:16];
            r0_theta <= s_axis_tdata[47 -: ANGLE_BITS];

            r1_q     <= r0_q;
            r1_d     <= r0_d;
            r1_theta <= 16'(r0_theta) << (16 - ANGLE_BITS);
            r1_dd    <= 32'(r0_d) * 32'(r0_d);
            r1_qq    <= 32'(r0_q) * 32'(r0_q);

            r_sn[0]   <= 32'(r1_dd) + 32'(r1_qq);
            r_sr[0]   <= '0;
            r_dnz[0]  <= (r1_d != 0);
            r_cneg[0] <= r1_q[15];
            r_qmag[0] <= r1_q[15] ? 16'(-r1_q) : 16'(r1_q);
            r_cth[0]  <= r1_theta;
            if (r1_d[15]) begin
                r_ax[0] <= -w_x0;
                r_ay[0] <= -w_y0;
                r_az[0] <= 21'(HALF_TURN);
            end else begin
                r_ax[0] <= w_x0;
                r_ay[0] <= w_y0;
                r_az[0] <= '0;
            end

            for (int k = 0; k < NST; k++) begin
                r_sn[k+1]   <= n_sn[k+1];
                r_sr[k+1]   <= n_sr[k+1];
                r_ax[k+1]   <= n_ax[k+1];
                r_ay[k+1]   <= n_ay[k+1];
                r_az[k+1]   <= n_az[k+1];
                r_dnz[k+1]  <= r_dnz[k];
                r_cneg[k+1] <= r_cneg[k];
                r_qmag[k+1] <= r_qmag[k];
                r_cth[k+1]  <= r_cth[k];
            end
        end
    end

    // Angle sum, wrap into one turn, divider and sine stages.
    logic signed [20:0] r19_sum;
    logic [15:0] r19_mag;
    logic        r19_neg;
    logic [15:0] r20_rem;
    logic signed [20:0] w_wrap;
    logic [18:0] w_angle;

    logic [14:0] r_dr   [0:NST];
    logic [15:0] r_dq   [0:NST];
    logic        r_dsat [0:NST];
    logic        r_dzer [0:NST];
    logic        r_dneg [0:NST];
    logic [2:0]  r_dsec [0:NST];
    logic [14:0] n_dr [1:NST];
    logic [15:0] n_dq [1:NST];

    always_comb begin
        if (r19_sum < 0) begin
            w_wrap = r19_sum + 21'(TURN_UNITS);
        end else if (r19_sum >= 21'(TURN_UNITS)) begin
            w_wrap = r19_sum - 21'(TURN_UNITS);
        end else begin
            w_wrap = r19_sum;
        end
        w_angle = w_wrap[18:0];
    end

    always_comb begin
        logic [15:0] t;
        for (int k = 0; k < NST; k++) begin
            t = {r_dr[k], 1'b0};
            if (t >= 16'(r_supply)) begin
                n_dr[k+1] = 15'(t - 16'(r_supply));
                n_dq[k+1] = {r_dq[k][14:0], 1'b1};
            end else begin
                n_dr[k+1] = t[14:0];
                n_dq[k+1] = {r_dq[k][14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r19_sum <= 21'({r_cth[NST], 2'b0}) + 21'({r_cth[NST], 1'b0})
                     + (r_dnz[NST] ? r_az[NST] : 21'(QUARTER_TURN));
            r19_mag <= r_dnz[NST] ? r_sr[NST][15:0] : r_qmag[NST];
            r19_neg <= !r_dnz[NST] && r_cneg[NST];

            r20_rem   <= w_angle[15:0];
            r_dsec[0] <= 3'(w_angle[18:16]) + 3'd1;
            r_dr[0]   <= r19_mag[14:0];
            r_dq[0]   <= '0;
            r_dsat[0] <= (r19_mag >= 16'(r_supply));
            r_dzer[0] <= (r19_mag == 0);
            r_dneg[0] <= r19_neg;

            for (int k = 0; k < NST; k++) begin
                r_dr[k+1]   <= n_dr[k+1];
                r_dq[k+1]   <= n_dq[k+1];
                r_dsat[k+1] <= r_dsat[k];
                r_dzer[k+1] <= r_dzer[k];
                r_dneg[k+1] <= r_dneg[k];
                r_dsec[k+1] <= r_dsec[k];
            end
        end
    end

    logic [14:0] w_sin1, w_sin2;

    svpd_sine u_sine_t1 (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_arg  (SECTOR_UNITS - 17'(r20_rem)),
        .o_sine (w_sin1)
    );

    svpd_sine u_sine_t2 (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_arg  (17'(r20_rem)),
        .o_sine (w_sin2)
    );

    // Timing products, zero-vector split and compare counts.
    logic signed [16:0] r37_m;
    logic [29:0] r37_p1, r37_p2;
    logic signed [47:0] r38_t1, r38_t2;
    logic signed [17:0] r39_t1, r39_t2, r40_t1, r40_t2;
    logic signed [19:0] r40_t0h;
    logic signed [19:0] r41_ta, r41_tb, r41_tc;
    logic [2:0]  r37_sec, r38_sec, r39_sec, r40_sec, r41_sec, r42_sec;
    logic [15:0] r42_a, r42_b, r42_c;
    logic [15:0] w_mq;
    logic signed [16:0] w_m;
    logic signed [19:0] w_t1, w_t2, w_half, w_t0;
    logic signed [47:0] w_bias1, w_bias2;

    always_comb begin
        if (r_dzer[NST]) begin
            w_mq = '0;
        end else if (r_dsat[NST] || r_dq[NST] > M_LIMIT) begin
            w_mq = M_LIMIT;
        end else begin
            w_mq = r_dq[NST];
        end
        w_m = r_dneg[NST] ? -$signed({1'b0, w_mq}) : $signed({1'b0, w_mq});

        w_bias1 = r38_t1 + ((r38_t1 < 0) ? 48'sd536870911 : 48'sd0);
        w_bias2 = r38_t2 + ((r38_t2 < 0) ? 48'sd536870911 : 48'sd0);

        w_t1   = 20'(r40_t1);
        w_t2   = 20'(r40_t2);
        w_half = r40_t0h;
        w_t0   = 20'sd65536 - 20'(r39_t1) - 20'(r39_t2);
    end

    function automatic logic [15:0] to_count(input logic signed [19:0] duty,
                                             input logic [15:0] period);
        logic [16:0] c;
        logic [32:0] p;
        if (duty < 0) begin
            c = '0;
        end else if (duty > 20'sd65536) begin
            c = 17'd65536;
        end else begin
            c = duty[16:0];
        end
        p = 33'(c) * 33'(period);
        return p[31:16];
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r37_m   <= w_m;
            r37_p1  <= 30'(SQRT3_Q14) * 30'(w_sin1);
            r37_p2  <= 30'(SQRT3_Q14) * 30'(w_sin2);
            r37_sec <= r_dsec[NST];

            r38_t1  <= 48'($signed({1'b0, r37_p1})) * 48'(r37_m);
            r38_t2  <= 48'($signed({1'b0, r37_p2})) * 48'(r37_m);
            r38_sec <= r37_sec;

            r39_t1  <= 18'(w_bias1 >>> 29);
            r39_t2  <= 18'(w_bias2 >>> 29);
            r39_sec <= r38_sec;

            r40_t1  <= r39_t1;
            r40_t2  <= r39_t2;
            r40_t0h <= w_t0 >>> 1;
            r40_sec <= r39_sec;

            r41_sec <= r40_sec;
            case (r40_sec)
                3'd1: begin
                    r41_ta <= w_t1 + w_t2 + w_half;
                    r41_tb <= w_t2 + w_half;
                    r41_tc <= w_half;
                end
                3'd2: begin
                    r41_ta <= w_t1 + w_half;
                    r41_tb <= w_t1 + w_t2 + w_half;
                    r41_tc <= w_half;
                end
                3'd3: begin
                    r41_ta <= w_half;
                    r41_tb <= w_t1 + w_t2 + w_half;
                    r41_tc <= w_t2 + w_half;
                end
                3'd4: begin
                    r41_ta <= w_half;
                    r41_tb <= w_t1 + w_half;
                    r41_tc <= w_t1 + w_t2 + w_half;
                end
                3'd5: begin
                    r41_ta <= w_t2 + w_half;
                    r41_tb <= w_half;
                    r41_tc <= w_t1 + w_t2 + w_half;
                end
                default: begin
                    r41_ta <= w_t1 + w_t2 + w_half;
                    r41_tb <= w_half;
                    r41_tc <= w_t1 + w_half;
                end
            endcase

            r42_a   <= to_count(r41_ta, r_period);
            r42_b   <= to_count(r41_tb, r_period);
            r42_c   <= to_count(r41_tc, r_period);
            r42_sec <= r41_sec;
        end
    end

    assign m_axis_tdata = {5'b0, r42_sec, r42_c, r42_b, r42_a};

endmodule

// ===== verif/tb_space_vector_pwm_duty.sv =====
`timescale 1ns / 1ps

module tb_space_vector_pwm_duty import svpd_pkg::*; ();

    typedef struct packed {
        logic [2:0]  sector;
        logic [15:0] duty_c;
        logic [15:0] duty_b;
        logic [15:0] duty_a;
    } duties_t;

    typedef struct {
        logic [15:0] q;
        logic [15:0] d;
        logic [15:0] ang;
        bit          typed;
        duties_t     want;
    } row_t;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 60;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;

    space_vector_pwm_duty uut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    duties_t     duty_queue[$];
    logic [13:0] supply_v = SUPPLY_RESET;
    logic [15:0] period_v = PERIOD_RESET;
    int          errors = 0;
    int          results_seen = 0;
    int          cycles = 0;
    bit          hold_req = 0;
    bit          no_idle = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int unsigned root32(int unsigned n);
        int unsigned r, b;
        r = 0;
        b = 32'h4000_0000;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint vec_angle(longint y, longint x);
        longint cx, cy, nx, z;
        z = 0;
        if (x < 0) begin
            cx = -x * 65536;
            cy = -y * 65536;
            z = TURN_UNITS / 2;
        end else begin
            cx = x * 65536;
            cy = y * 65536;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (cy > 0) begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                z = z + longint'(ATAN_UNITS[i]);
            end else begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                z = z - longint'(ATAN_UNITS[i]);
            end
            cx = nx;
        end
        return z;
    endfunction

    function automatic longint sine15(longint arg);
        longint x, y, nx, z;
        x = CORDIC_K_Q15;
        y = 0;
        z = arg;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(ATAN_UNITS[i]);
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(ATAN_UNITS[i]);
            end
            x = nx;
        end
        if (y < 0) y = 0;
        if (y > 32767) y = 32767;
        return y;
    endfunction

    function automatic logic [15:0] compare_count(longint duty);
        longint p;
        p = period_v;
        if (duty < 0) duty = 0;
        if (duty > 65536) duty = 65536;
        return 16'((duty * p) >> 16);
    endfunction

    function automatic duties_t predict_duties(logic [15:0] qv, logic [15:0] dv,
                                               logic [15:0] av);
        longint q, d, mag, offs, ang, m, sec, rem, t1, t2, t0h, ta, tb, tc;
        longint s1, s2;
        bit neg;
        duties_t r;
        q = longint'($signed(qv));
        d = longint'($signed(dv));
        neg = 0;
        if (d != 0) begin
            mag = root32(32'(d * d + q * q));
            offs = vec_angle(q, d);
        end else begin
            neg = q < 0;
            mag = neg ? -q : q;
            offs = TURN_UNITS / 4;
        end
        ang = (longint'(av) * 6 + offs) % longint'(TURN_UNITS);
        if (ang < 0) ang = ang + longint'(TURN_UNITS);
        if (supply_v == 0) begin
            m = (mag != 0) ? M_LIMIT : 0;
        end else begin
            m = (mag << 16) / longint'(supply_v);
            if (m > M_LIMIT) m = M_LIMIT;
        end
        if (neg) m = -m;
        sec = ang / SECTOR_UNITS + 1;
        rem = ang % SECTOR_UNITS;
        s1 = sine15(SECTOR_UNITS - rem);
        s2 = sine15(rem);
        t1 = (longint'(SQRT3_Q14) * s1 * m) / (longint'(1) << 29);
        t2 = (longint'(SQRT3_Q14) * s2 * m) / (longint'(1) << 29);
        t0h = (65536 - t1 - t2) >>> 1;
        case (sec)
            1: begin ta = t1 + t2 + t0h; tb = t2 + t0h; tc = t0h; end
            2: begin ta = t1 + t0h; tb = t1 + t2 + t0h; tc = t0h; end
            3: begin ta = t0h; tb = t1 + t2 + t0h; tc = t2 + t0h; end
            4: begin ta = t0h; tb = t1 + t0h; tc = t1 + t2 + t0h; end
            5: begin ta = t2 + t0h; tb = t0h; tc = t1 + t2 + t0h; end
            default: begin ta = t1 + t2 + t0h; tb = t0h; tc = t1 + t0h; end
        endcase
        r.duty_a = compare_count(ta);
        r.duty_b = compare_count(tb);
        r.duty_c = compare_count(tc);
        r.sector = 3'(sec);
        return r;
    endfunction

    task automatic send_command(logic [15:0] q, logic [15:0] d, logic [15:0] a,
                                bit typed, duties_t want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata <= {a, d, q};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        duty_queue.push_back(typed ? want : predict_duties(q, d, a));
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_SUPPLY) supply_v = val[13:0];
        else period_v = val;
    endtask

    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        while (duty_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_command();
        logic [15:0] q, d, a;
        int pick;
        q = 16'($urandom);
        d = 16'($urandom);
        a = 16'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 2) d = '0;
        else if (pick == 2) begin
            q = 16'($signed(10'($urandom)));
            d = 16'($signed(10'($urandom)));
        end else if (pick == 3) begin
            q = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
            d = ($urandom_range(0, 2) == 0) ? 16'h0000 :
                (($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF);
        end
        send_command(q, d, a, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            duties_t got, want;
            got = duties_t'(m_axis_tdata[50:0]);
            if (duty_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = duty_queue.pop_front();
                results_seen++;
                if (got.duty_a !== want.duty_a) begin
                    $display("%0t: duty_a expected %0d got %0d", $time, want.duty_a, got.duty_a);
                    errors++;
                end
                if (got.duty_b !== want.duty_b) begin
                    $display("%0t: duty_b expected %0d got %0d", $time, want.duty_b, got.duty_b);
                    errors++;
                end
                if (got.duty_c !== want.duty_c) begin
                    $display("%0t: duty_c expected %0d got %0d", $time, want.duty_c, got.duty_c);
                    errors++;
                end
                if (got.sector !== want.sector) begin
                    $display("%0t: sector expected %0d got %0d", $time, want.sector, got.sector);
                    errors++;
                end
            end
        end
    end

    initial begin
        int gap;
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 18);
            if (hold_req) begin
                gap = 300;
                hold_req = 0;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    row_t directed[] = '{
        '{16'h0000, 16'h0000, 16'h0000, 1, '{3'd2, 16'd640, 16'd640, 16'd640}},
        '{16'h0000, 16'h0000, 16'hFFFF, 1, '{3'd2, 16'd640, 16'd640, 16'd640}},
        '{16'h0000, 16'h0000, 16'h8000, 1, '{3'd5, 16'd640, 16'd640, 16'd640}},
        '{16'h7FFF, 16'h0000, 16'h0000, 0, '0},
        '{16'h8000, 16'h0000, 16'h0000, 0, '0},
        '{16'hFF00, 16'h0000, 16'h4000, 0, '0},
        '{16'h0100, 16'h0000, 16'hC000, 0, '0},
        '{16'h0000, 16'h7FFF, 16'h0000, 0, '0},
        '{16'h0000, 16'h8000, 16'h0000, 0, '0},
        '{16'h7FFF, 16'h7FFF, 16'hFFFF, 0, '0},
        '{16'h8000, 16'h8000, 16'h2AAA, 0, '0},
        '{16'h7FFF, 16'h8000, 16'h5555, 0, '0},
        '{16'h8000, 16'h7FFF, 16'hAAAA, 0, '0},
        '{16'h0000, 16'h0001, 16'h0001, 0, '0},
        '{16'h0000, 16'hFFFF, 16'hD555, 0, '0},
        '{16'h0C00, 16'h0000, 16'h1555, 0, '0},
        '{16'h0400, 16'h0300, 16'h7000, 0, '0},
        '{16'hFC00, 16'hFD00, 16'h9000, 0, '0}
    };

    logic [15:0] phase_supply[] = '{16'd256, 16'd16383, 16'd0, 16'd3072, 16'd1000,
                                    16'd300, 16'd8000, 16'd12000, 16'd2048, 16'd16383};
    logic [15:0] phase_period[] = '{16'd65535, 16'd1, 16'd0, 16'd1280, 16'd4000,
                                    16'd65535, 16'd2, 16'd30000, 16'd999, 16'd50000};

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k])
            send_command(directed[k].q, directed[k].d, directed[k].ang,
                         directed[k].typed, directed[k].want);
        drain_pipe();
        foreach (phase_supply[p]) begin
            write_reg(CFG_SUPPLY, phase_supply[p]);
            write_reg(CFG_PERIOD, phase_period[p]);
            i_cfg_valid <= 1'b0;
            no_idle = (p == 4);
            if (p == 6) hold_req = 1;
            foreach (directed[k])
                if (p < 3) send_command(directed[k].q, directed[k].d, directed[k].ang,
                                        1'b0, '0);
            repeat (105) random_command();
            drain_pipe();
        end
        $display("Ran %0d results over %0d register settings, including zero supply,",
                 results_seen, phase_supply.size() + 1);
        $display("zero and full period, q-only negative commands and a long output stall.");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
